// File: design/pid_controller_step_macros.svh
// ---------------------------------------------------------------------------
// pid_controller_step_macros.svh
// Assertion macros for the PID step block; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef PID_CONTROLLER_STEP_MACROS_SVH
`define PID_CONTROLLER_STEP_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PCS_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error("pcs assertion failed");

// next-cycle implication
`define PCS_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error("pcs assertion failed");

`else

`define PCS_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define PCS_ASSERT_NEXT(lbl, ck, rn, ante, cons)

`endif

`endif

// File: design/pcs_pkg.sv
// ---------------------------------------------------------------------------
// pcs_pkg
// Widths, codes and fixed-point helpers for the PID step block.
// ---------------------------------------------------------------------------
package pcs_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int LIM_W     = DATA_W - 1;
    localparam int CFG_IDX_W = 3;
    localparam int EXT_W     = DATA_W + 1;
    localparam int SUM_W     = DATA_W + 2;
    localparam int ALU_W     = DATA_W + 2;
    localparam int PROD_W    = 2 * DATA_W + 1;
    localparam int MAG_W     = PROD_W - FRAC_BITS + 1;
    localparam int WIDE_W    = MAG_W + 1;
    localparam int DVD_W     = EXT_W + FRAC_BITS;
    localparam int QUO_W     = DATA_W - 1;
    localparam int REM0_W    = DVD_W - QUO_W;
    localparam int CNT_W     = $clog2(DATA_W + 1);

    localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P        = 3'd0,
        REG_GAIN_I        = 3'd1,
        REG_GAIN_D        = 3'd2,
        REG_INCREMENTAL   = 3'd3,
        REG_WINDUP_ON     = 3'd4,
        REG_WINDUP_LIMIT  = 3'd5,
        REG_DERIV_ON      = 3'd6,
        REG_DERIV_LIMIT   = 3'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        TERM_P = 2'd0,
        TERM_I = 2'd1,
        TERM_D = 2'd2
    } term_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_PREP,
        S_TMUL,
        S_TACC,
        S_DINIT,
        S_DIV,
        S_DFIN,
        S_WCLAMP,
        S_GLOAD,
        S_GMUL,
        S_GFIN,
        S_SUM
    } pcs_state_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic [WIDE_W-DATA_W:0] top;
        top = v[WIDE_W-1:DATA_W-1];
        if (top == '0 || top == '1)
            return v[DATA_W-1:0];
        else
            return v[WIDE_W-1] ? DATA_MIN : DATA_MAX;
    endfunction

    // floor(+-prod / 2^k), k = FRAC_BITS or FRAC_BITS+1
    function automatic logic signed [WIDE_W-1:0] floor_scale(
        input logic [PROD_W-1:0] prod,
        input logic              neg,
        input logic              half
    );
        logic [PROD_W-1:0] sh;
        logic [PROD_W-1:0] mask;
        logic [MAG_W-1:0]  mag;
        sh   = half ? (prod >> (FRAC_BITS + 1)) : (prod >> FRAC_BITS);
        mask = half ? ((PROD_W'(1) << (FRAC_BITS + 1)) - PROD_W'(1))
                    : ((PROD_W'(1) << FRAC_BITS) - PROD_W'(1));
        mag  = MAG_W'(sh) + MAG_W'(neg && ((prod & mask) != '0));
        return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

    function automatic logic signed [DATA_W-1:0] clamp_mag(
        input logic signed [DATA_W-1:0] v,
        input logic [LIM_W-1:0]         lim
    );
        logic signed [DATA_W-1:0] lim_s;
        lim_s = $signed({1'b0, lim});
        if (v > lim_s)
            return lim_s;
        else if (v < -lim_s)
            return -lim_s;
        else
            return v;
    endfunction

endpackage

// File: design/pcs_if.sv
// ---------------------------------------------------------------------------
// pcs_if
// Valid/ready channels carrying PID step requests and results.
// ---------------------------------------------------------------------------
interface pcs_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [pcs_pkg::DATA_W-1:0] target;
    logic signed [pcs_pkg::DATA_W-1:0] measured;
    logic [pcs_pkg::DATA_W-1:0]        time_step;
    logic                              clear_state;

    modport source (output valid, target, measured, time_step, clear_state, input ready);
    modport sink   (input valid, target, measured, time_step, clear_state, output ready);
endinterface

interface pcs_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [pcs_pkg::DATA_W-1:0] control;
    logic signed [pcs_pkg::DATA_W-1:0] p_term;
    logic signed [pcs_pkg::DATA_W-1:0] i_term;
    logic signed [pcs_pkg::DATA_W-1:0] d_term;
    logic signed [pcs_pkg::DATA_W-1:0] integral_value;
    logic                              zero_step_fault;

    modport source (output valid, control, p_term, i_term, d_term, integral_value,
                    zero_step_fault, input ready);
    modport sink   (input valid, control, p_term, i_term, d_term, integral_value,
                    zero_step_fault, output ready);
endinterface

// File: design/pid_controller_step.sv
// ---------------------------------------------------------------------------
// pid_controller_step
// Fixed-point PID step: trapezoid integral, divided derivative, gain products.
// ---------------------------------------------------------------------------
// One request is taken at a time, and a new one is taken once the result
// has been loaded into the output register. The divide is skipped when the
// derivative quotient overflows, and the trapezoid multiplication and the
// divide are skipped when time_step is zero. The block uses a single 34-bit
// add/subtract unit that runs four 32-step shift-add multiplications
// (trapezoid and the three gains) and one 31-step restoring division, one
// bit per cycle. The result sits in an output register, so the next
// request is accepted while it waits for a transfer. Config writes are
// honored at any time but belong between requests.
module pid_controller_step (
    input  logic                               clk,
    input  logic                               rst_n,
    pcs_in_if.sink                             in_ch,
    pcs_out_if.source                          out_ch,
    input  logic                               cfg_we,
    input  logic [pcs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pcs_pkg::DATA_W-1:0]         cfg_data
);

`include "pid_controller_step_macros.svh"

    localparam int DW = pcs_pkg::DATA_W;

    pcs_pkg::pcs_state_t state_reg, state_next;

    // config
    logic signed [DW-1:0]          gain_p_reg, gain_i_reg, gain_d_reg;
    logic                          incremental_reg, windup_on_reg, deriv_on_reg;
    logic [pcs_pkg::LIM_W-1:0]     windup_limit_reg, deriv_limit_reg;

    // kept state
    logic signed [DW-1:0] last_error_reg, last_error_next;
    logic signed [DW-1:0] integral_reg, integral_next;
    logic signed [DW-1:0] last_control_reg, last_control_next;

    // control
    logic [pcs_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    pcs_pkg::term_t            term_reg, term_next;
    logic                      out_valid_reg, out_valid_next;

    // working payload
    logic signed [DW-1:0]       tgt_reg, tgt_next;
    logic signed [DW-1:0]       meas_reg, meas_next;
    logic [DW-1:0]              dt_reg, dt_next;
    logic signed [DW-1:0]       err_reg, err_next;
    logic [pcs_pkg::EXT_W-1:0]  acc_hi_reg, acc_hi_next;
    logic [DW-1:0]              shift_reg, shift_next;
    logic [pcs_pkg::EXT_W-1:0]  mcand_reg, mcand_next;
    logic                       neg_reg, neg_next;
    logic                       ovf_reg, ovf_next;
    logic                       fault_reg, fault_next;
    logic signed [DW-1:0]       deriv_reg, deriv_next;
    logic signed [DW-1:0]       p_reg, p_next;
    logic signed [DW-1:0]       i_reg, i_next;
    logic signed [DW-1:0]       d_reg, d_next;

    // result register
    logic signed [DW-1:0] control_reg, control_next;
    logic signed [DW-1:0] p_out_reg, p_out_next;
    logic signed [DW-1:0] i_out_reg, i_out_next;
    logic signed [DW-1:0] d_out_reg, d_out_next;
    logic signed [DW-1:0] integ_out_reg, integ_out_next;
    logic                 fault_out_reg, fault_out_next;

    // shared add/subtract unit
    logic [pcs_pkg::ALU_W-1:0] alu_a, alu_b, alu_y;
    logic                      alu_sub;
    logic                      alu_ge;

    // combinational helpers
    logic signed [pcs_pkg::EXT_W-1:0]  err_wide;
    logic signed [pcs_pkg::EXT_W-1:0]  s_wide, diff_wide;
    logic [pcs_pkg::EXT_W-1:0]         s_mag, diff_mag;
    logic [pcs_pkg::DVD_W-1:0]         dividend;
    logic [pcs_pkg::REM0_W-1:0]        rem0;
    logic [pcs_pkg::PROD_W-1:0]        prod;
    logic signed [pcs_pkg::WIDE_W-1:0] integ_sum;
    logic signed [pcs_pkg::SUM_W-1:0]  u_sum;
    logic signed [DW-1:0]              u_sat;
    logic signed [DW-1:0]              term_val;
    logic signed [DW-1:0]              x_sel, g_sel;
    logic [DW-1:0]                     x_abs, g_abs, quo;
    logic                              out_free, out_load, in_take;

    assign in_ch.ready = (state_reg == pcs_pkg::S_IDLE);
    assign in_take     = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign out_load    = (state_reg == pcs_pkg::S_SUM) && out_free;

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.control         = control_reg;
    assign out_ch.p_term          = p_out_reg;
    assign out_ch.i_term          = i_out_reg;
    assign out_ch.d_term          = d_out_reg;
    assign out_ch.integral_value  = integ_out_reg;
    assign out_ch.zero_step_fault = fault_out_reg;

    assign err_wide  = pcs_pkg::EXT_W'(tgt_reg) - pcs_pkg::EXT_W'(meas_reg);
    assign s_wide    = pcs_pkg::EXT_W'(err_reg) + pcs_pkg::EXT_W'(last_error_reg);
    assign diff_wide = pcs_pkg::EXT_W'(err_reg) - pcs_pkg::EXT_W'(last_error_reg);
    assign s_mag     = s_wide[pcs_pkg::EXT_W-1] ? pcs_pkg::EXT_W'(-s_wide)
                                                : pcs_pkg::EXT_W'(s_wide);
    assign diff_mag  = diff_wide[pcs_pkg::EXT_W-1] ? pcs_pkg::EXT_W'(-diff_wide)
                                                   : pcs_pkg::EXT_W'(diff_wide);
    assign dividend  = {diff_mag, {pcs_pkg::FRAC_BITS{1'b0}}};
    assign rem0      = dividend[pcs_pkg::DVD_W-1 -: pcs_pkg::REM0_W];
    assign prod      = {acc_hi_reg, shift_reg};
    assign quo       = ovf_reg ? DW'(pcs_pkg::DATA_MIN) : {1'b0, shift_reg[pcs_pkg::QUO_W-1:0]};

    assign integ_sum = pcs_pkg::WIDE_W'(integral_reg)
                     + pcs_pkg::floor_scale(prod, neg_reg, 1'b1);
    assign term_val  = pcs_pkg::sat32(pcs_pkg::floor_scale(prod, neg_reg, 1'b0));
    assign u_sum     = pcs_pkg::SUM_W'(p_reg) + pcs_pkg::SUM_W'(i_reg)
                     + pcs_pkg::SUM_W'(d_reg)
                     + (incremental_reg ? pcs_pkg::SUM_W'(last_control_reg)
                                        : pcs_pkg::SUM_W'(0));
    assign u_sat     = pcs_pkg::sat32(pcs_pkg::WIDE_W'(u_sum));

    always_comb
    begin
        case (term_reg)
            pcs_pkg::TERM_I:
            begin
                x_sel = integral_reg;
                g_sel = gain_i_reg;
            end
            pcs_pkg::TERM_D:
            begin
                x_sel = deriv_reg;
                g_sel = gain_d_reg;
            end
            default:
            begin
                x_sel = err_reg;
                g_sel = gain_p_reg;
            end
        endcase
        x_abs = x_sel[DW-1] ? DW'(-x_sel) : DW'(x_sel);
        g_abs = g_sel[DW-1] ? DW'(-g_sel) : DW'(g_sel);
    end

    // shared ALU operand select
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            pcs_pkg::S_TMUL, pcs_pkg::S_GMUL:
            begin
                alu_a = {1'b0, acc_hi_reg};
                alu_b = shift_reg[0] ? {1'b0, mcand_reg} : '0;
            end
            pcs_pkg::S_DINIT:
            begin
                alu_a   = pcs_pkg::ALU_W'(rem0);
                alu_b   = pcs_pkg::ALU_W'(dt_reg);
                alu_sub = 1'b1;
            end
            pcs_pkg::S_DIV:
            begin
                alu_a   = {1'b0, acc_hi_reg[DW-1:0], shift_reg[DW-1]};
                alu_b   = pcs_pkg::ALU_W'(dt_reg);
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
    end

    assign alu_y  = alu_a + (alu_sub ? ~alu_b : alu_b) + pcs_pkg::ALU_W'(alu_sub);
    assign alu_ge = !alu_y[pcs_pkg::ALU_W-1];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pcs_pkg::S_IDLE:   if (in_take) state_next = pcs_pkg::S_ERR;
            pcs_pkg::S_ERR:    state_next = pcs_pkg::S_PREP;
            pcs_pkg::S_PREP:   state_next = (dt_reg == '0) ? pcs_pkg::S_WCLAMP
                                                           : pcs_pkg::S_TMUL;
            pcs_pkg::S_TMUL:   if (cnt_reg == pcs_pkg::CNT_W'(1)) state_next = pcs_pkg::S_TACC;
            pcs_pkg::S_TACC:   state_next = pcs_pkg::S_DINIT;
            pcs_pkg::S_DINIT:  state_next = alu_ge ? pcs_pkg::S_DFIN : pcs_pkg::S_DIV;
            pcs_pkg::S_DIV:    if (cnt_reg == pcs_pkg::CNT_W'(1)) state_next = pcs_pkg::S_DFIN;
            pcs_pkg::S_DFIN:   state_next = pcs_pkg::S_WCLAMP;
            pcs_pkg::S_WCLAMP: state_next = pcs_pkg::S_GLOAD;
            pcs_pkg::S_GLOAD:  state_next = pcs_pkg::S_GMUL;
            pcs_pkg::S_GMUL:   if (cnt_reg == pcs_pkg::CNT_W'(1)) state_next = pcs_pkg::S_GFIN;
            pcs_pkg::S_GFIN:   state_next = (term_reg == pcs_pkg::TERM_D) ? pcs_pkg::S_SUM
                                                                         : pcs_pkg::S_GLOAD;
            pcs_pkg::S_SUM:    if (out_free) state_next = pcs_pkg::S_IDLE;
            default:           state_next = pcs_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        last_error_next   = last_error_reg;
        integral_next     = integral_reg;
        last_control_next = last_control_reg;
        cnt_next          = cnt_reg;
        term_next         = term_reg;
        tgt_next          = tgt_reg;
        meas_next         = meas_reg;
        dt_next           = dt_reg;
        err_next          = err_reg;
        acc_hi_next       = acc_hi_reg;
        shift_next        = shift_reg;
        mcand_next        = mcand_reg;
        neg_next          = neg_reg;
        ovf_next          = ovf_reg;
        fault_next        = fault_reg;
        deriv_next        = deriv_reg;
        p_next            = p_reg;
        i_next            = i_reg;
        d_next            = d_reg;
        control_next      = control_reg;
        p_out_next        = p_out_reg;
        i_out_next        = i_out_reg;
        d_out_next        = d_out_reg;
        integ_out_next    = integ_out_reg;
        fault_out_next    = fault_out_reg;
        out_valid_next    = out_valid_reg && !out_ch.ready;

        unique case (state_reg)
            pcs_pkg::S_IDLE:
            begin
                if (in_take)
                begin
                    tgt_next  = in_ch.target;
                    meas_next = in_ch.measured;
                    dt_next   = in_ch.time_step;
                    if (in_ch.clear_state)
                    begin
                        last_error_next   = '0;
                        integral_next     = '0;
                        last_control_next = '0;
                    end
                end
            end
            pcs_pkg::S_ERR:
            begin
                err_next = pcs_pkg::sat32(pcs_pkg::WIDE_W'(err_wide));
            end
            pcs_pkg::S_PREP:
            begin
                fault_next = (dt_reg == '0);
                ovf_next   = 1'b0;
                if (dt_reg == '0)
                begin
                    deriv_next = '0;
                end
                else
                begin
                    mcand_next  = s_mag;
                    shift_next  = dt_reg;
                    acc_hi_next = '0;
                    neg_next    = s_wide[pcs_pkg::EXT_W-1];
                    cnt_next    = pcs_pkg::CNT_W'(DW);
                end
            end
            pcs_pkg::S_TMUL, pcs_pkg::S_GMUL:
            begin
                acc_hi_next = alu_y[pcs_pkg::ALU_W-1:1];
                shift_next  = {alu_y[0], shift_reg[DW-1:1]};
                cnt_next    = cnt_reg - pcs_pkg::CNT_W'(1);
            end
            pcs_pkg::S_TACC:
            begin
                integral_next = pcs_pkg::sat32(integ_sum);
            end
            pcs_pkg::S_DINIT:
            begin
                ovf_next = alu_ge;
                if (!alu_ge)
                begin
                    acc_hi_next = pcs_pkg::EXT_W'(rem0);
                    shift_next  = {dividend[pcs_pkg::QUO_W-1:0], 1'b0};
                    cnt_next    = pcs_pkg::CNT_W'(pcs_pkg::QUO_W);
                end
            end
            pcs_pkg::S_DIV:
            begin
                acc_hi_next = alu_ge ? pcs_pkg::EXT_W'(alu_y[DW-1:0])
                                     : alu_a[pcs_pkg::EXT_W-1:0];
                shift_next  = {shift_reg[DW-2:0], alu_ge};
                cnt_next    = cnt_reg - pcs_pkg::CNT_W'(1);
            end
            pcs_pkg::S_DFIN:
            begin
                if (diff_wide[pcs_pkg::EXT_W-1])
                    deriv_next = -$signed(quo);
                else
                    deriv_next = ovf_reg ? pcs_pkg::DATA_MAX : $signed(quo);
            end
            pcs_pkg::S_WCLAMP:
            begin
                if (windup_on_reg)
                    integral_next = pcs_pkg::clamp_mag(integral_reg, windup_limit_reg);
                term_next = pcs_pkg::TERM_P;
            end
            pcs_pkg::S_GLOAD:
            begin
                mcand_next  = {1'b0, x_abs};
                shift_next  = g_abs;
                acc_hi_next = '0;
                neg_next    = x_sel[DW-1] ^ g_sel[DW-1];
                cnt_next    = pcs_pkg::CNT_W'(DW);
            end
            pcs_pkg::S_GFIN:
            begin
                case (term_reg)
                    pcs_pkg::TERM_P:
                    begin
                        p_next    = term_val;
                        term_next = pcs_pkg::TERM_I;
                    end
                    pcs_pkg::TERM_I:
                    begin
                        i_next    = term_val;
                        term_next = pcs_pkg::TERM_D;
                    end
                    default:
                    begin
                        d_next = deriv_on_reg ? pcs_pkg::clamp_mag(term_val, deriv_limit_reg)
                                              : term_val;
                    end
                endcase
            end
            pcs_pkg::S_SUM:
            begin
                if (out_load)
                begin
                    control_next      = u_sat;
                    p_out_next        = p_reg;
                    i_out_next        = i_reg;
                    d_out_next        = d_reg;
                    integ_out_next    = integral_reg;
                    fault_out_next    = fault_reg;
                    out_valid_next    = 1'b1;
                    last_error_next   = err_reg;
                    last_control_next = u_sat;
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= pcs_pkg::S_IDLE;
            cnt_reg          <= '0;
            term_reg         <= pcs_pkg::TERM_P;
            out_valid_reg    <= 1'b0;
            last_error_reg   <= '0;
            integral_reg     <= '0;
            last_control_reg <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            term_reg         <= term_next;
            out_valid_reg    <= out_valid_next;
            last_error_reg   <= last_error_next;
            integral_reg     <= integral_next;
            last_control_reg <= last_control_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg       <= '0;
            gain_i_reg       <= '0;
            gain_d_reg       <= '0;
            incremental_reg  <= 1'b0;
            windup_on_reg    <= 1'b0;
            windup_limit_reg <= '1;
            deriv_on_reg     <= 1'b0;
            deriv_limit_reg  <= '1;
        end
        else if (cfg_we)
        begin
            unique case (pcs_pkg::cfg_reg_t'(cfg_index))
                pcs_pkg::REG_GAIN_P:       gain_p_reg       <= $signed(cfg_data);
                pcs_pkg::REG_GAIN_I:       gain_i_reg       <= $signed(cfg_data);
                pcs_pkg::REG_GAIN_D:       gain_d_reg       <= $signed(cfg_data);
                pcs_pkg::REG_INCREMENTAL:  incremental_reg  <= cfg_data[0];
                pcs_pkg::REG_WINDUP_ON:    windup_on_reg    <= cfg_data[0];
                pcs_pkg::REG_WINDUP_LIMIT: windup_limit_reg <= cfg_data[pcs_pkg::LIM_W-1:0];
                pcs_pkg::REG_DERIV_ON:     deriv_on_reg     <= cfg_data[0];
                pcs_pkg::REG_DERIV_LIMIT:  deriv_limit_reg  <= cfg_data[pcs_pkg::LIM_W-1:0];
                default:                   gain_p_reg       <= gain_p_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        tgt_reg       <= tgt_next;
        meas_reg      <= meas_next;
        dt_reg        <= dt_next;
        err_reg       <= err_next;
        acc_hi_reg    <= acc_hi_next;
        shift_reg     <= shift_next;
        mcand_reg     <= mcand_next;
        neg_reg       <= neg_next;
        ovf_reg       <= ovf_next;
        fault_reg     <= fault_next;
        deriv_reg     <= deriv_next;
        p_reg         <= p_next;
        i_reg         <= i_next;
        d_reg         <= d_next;
        control_reg   <= control_next;
        p_out_reg     <= p_out_next;
        i_out_reg     <= i_out_next;
        d_out_reg     <= d_out_next;
        integ_out_reg <= integ_out_next;
        fault_out_reg <= fault_out_next;
    end

    `PCS_ASSERT_NEXT(a_control_kept, clk, rst_n, out_load, control_reg == last_control_reg)
    `PCS_ASSERT_IMP(a_fault_zero_d, clk, rst_n, out_valid_reg && fault_out_reg, d_out_reg == '0)
    `PCS_ASSERT_IMP(a_cnt_parked, clk, rst_n, (state_reg != pcs_pkg::S_TMUL) && (state_reg != pcs_pkg::S_DIV) && (state_reg != pcs_pkg::S_GMUL), cnt_reg == '0)

endmodule
